[src/pp3d_pkg.sv]
// ----------------------------------------------------------------------------
// pp3d_pkg
// Types and constants shared by the point-to-3D blocks.
// ----------------------------------------------------------------------------
package pp3d_pkg;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [3:0] COUNT_MAX = 4'd15;

  typedef enum logic [2:0] {
    REG_FOCAL_X    = 3'd0,
    REG_FOCAL_Y    = 3'd1,
    REG_CENTER_X   = 3'd2,
    REG_CENTER_Y   = 3'd3,
    REG_RADIAL_K1  = 3'd4,
    REG_RADIAL_K2  = 3'd5,
    REG_BASELINE   = 3'd6,
    REG_MIN_WEIGHT = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FEW_POINTS = 2'd1,
    STATUS_BAD_SOURCE = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic [15:0]        focal_x;
    logic [15:0]        focal_y;
    logic [15:0]        center_x;
    logic [15:0]        center_y;
    logic signed [15:0] radial_k1;
    logic signed [15:0] radial_k2;
    logic [15:0]        baseline;
    logic [15:0]        min_weight;
  } cfg_t;

  typedef struct packed {
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [15:0] weight;
    logic [15:0] image_size;
    logic        source_valid;
    logic        last_point;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         slot;
    logic               point_ok;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [23:0]        depth;
    logic               frame_end;
    logic [1:0]         frame_status;
    logic [3:0]         valid_total;
  } out_item_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  slot;
    logic        frame_end;
    logic [1:0]  status;
    logic [3:0]  valid_total;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [15:0] image_size;
  } job_t;

  typedef struct packed {
    logic [17:0] rem0;
    logic [31:0] bits;
    logic [17:0] den;
    logic [4:0]  half_steps;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

endpackage

[src/pp3d_if.sv]
// ----------------------------------------------------------------------------
// pp3d_in_if / pp3d_out_if
// Valid/ready channels carrying input points and results.
// ----------------------------------------------------------------------------
interface pp3d_in_if;
  logic                valid;
  logic                ready;
  pp3d_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pp3d_out_if;
  logic                valid;
  logic                ready;
  pp3d_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[src/pinhole_point_to_3d.sv]
// ----------------------------------------------------------------------------
// pinhole_point_to_3d
// Marker image points to camera-frame 3D positions, pinhole model with
// radial distortion correction.
// ----------------------------------------------------------------------------
// One result per accepted point, in order. A dropped point goes from the
// queue straight to the output state; a computed point uses the shared
// divider (two quotient bits a cycle) for up to five divisions in turn and
// the shared multiplier for ten passes. A two-entry queue behind the input
// lets next points be taken while one is worked on and its result waits in
// the output register. Registers are written through cfg_we, cfg_index and
// cfg_data; the user must do so while the block is idle (it is not enforced).
module pinhole_point_to_3d #(
  parameter int MARKER_SLOTS     = 8,
  parameter int MIN_VALID_POINTS = 3,
  parameter int MIN_DEPTH_Q16    = 3277,
  parameter int MAX_DEPTH_Q16    = 655360
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pp3d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pp3d_pkg::CFG_DATA_W-1:0]    cfg_data,
  pp3d_in_if.sink                            in_ch,
  pp3d_out_if.source                         out_ch
);

  pp3d_pkg::cfg_t     cfg_r;
  logic               push_valid;
  logic               push_ready;
  pp3d_pkg::job_t     push_job;
  logic               pop_valid;
  logic               pop_ready;
  pp3d_pkg::job_t     pop_job;
  logic               div_start;
  pp3d_pkg::div_req_t div_req;
  pp3d_pkg::div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal_x    <= 16'd5120;
      cfg_r.focal_y    <= 16'd5120;
      cfg_r.center_x   <= 16'd10240;
      cfg_r.center_y   <= 16'd7680;
      cfg_r.radial_k1  <= 16'sd0;
      cfg_r.radial_k2  <= 16'sd0;
      cfg_r.baseline   <= 16'd3277;
      cfg_r.min_weight <= 16'd16384;
    end else if (cfg_we) begin
      case (pp3d_pkg::cfg_reg_t'(cfg_index))
        pp3d_pkg::REG_FOCAL_X:    cfg_r.focal_x    <= cfg_data;
        pp3d_pkg::REG_FOCAL_Y:    cfg_r.focal_y    <= cfg_data;
        pp3d_pkg::REG_CENTER_X:   cfg_r.center_x   <= cfg_data;
        pp3d_pkg::REG_CENTER_Y:   cfg_r.center_y   <= cfg_data;
        pp3d_pkg::REG_RADIAL_K1:  cfg_r.radial_k1  <= cfg_data;
        pp3d_pkg::REG_RADIAL_K2:  cfg_r.radial_k2  <= cfg_data;
        pp3d_pkg::REG_BASELINE:   cfg_r.baseline   <= cfg_data;
        pp3d_pkg::REG_MIN_WEIGHT: cfg_r.min_weight <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pp3d_front #(
    .MARKER_SLOTS     (MARKER_SLOTS),
    .MIN_VALID_POINTS (MIN_VALID_POINTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_ch.payload),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  pp3d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  pp3d_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pp3d_back #(
    .MIN_DEPTH_Q16 (MIN_DEPTH_Q16),
    .MAX_DEPTH_Q16 (MAX_DEPTH_Q16)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (pop_valid),
    .job_pop   (pop_ready),
    .job       (pop_job),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.payload),
    .div_start (div_start),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

endmodule

[src/pp3d_front.sv]
// ----------------------------------------------------------------------------
// pp3d_front
// Classifies each point, keeps the frame counters and queues the job.
// ----------------------------------------------------------------------------
module pp3d_front #(
  parameter int MARKER_SLOTS     = 8,
  parameter int MIN_VALID_POINTS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pp3d_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  pp3d_pkg::in_item_t in_item,
  output logic               push_valid,
  input  logic               push_ready,
  output pp3d_pkg::job_t     push_job
);

  logic [3:0] slot_r;
  logic [3:0] valid_cnt_r;
  logic       src_bad_r;
  logic       bad;
  logic       ok;
  logic [3:0] valid_nxt;
  logic [1:0] status;
  logic       xfer;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign xfer       = in_valid && push_ready;

  always_comb begin
    bad = src_bad_r | ~in_item.source_valid;
    ok  = !bad && (in_item.weight >= cfg.min_weight) && (in_item.image_size != 16'd0) &&
          (slot_r < 4'(MARKER_SLOTS)) && (cfg.focal_x != 16'd0) && (cfg.focal_y != 16'd0);
    valid_nxt = (ok && valid_cnt_r < pp3d_pkg::COUNT_MAX) ? valid_cnt_r + 4'd1 : valid_cnt_r;
    status = pp3d_pkg::STATUS_OK;
    if (in_item.last_point) begin
      if (bad) begin
        status = pp3d_pkg::STATUS_BAD_SOURCE;
      end else if (valid_nxt < 4'(MIN_VALID_POINTS)) begin
        status = pp3d_pkg::STATUS_FEW_POINTS;
      end
    end
    push_job.ok          = ok;
    push_job.slot        = slot_r[2:0];
    push_job.frame_end   = in_item.last_point;
    push_job.status      = status;
    push_job.valid_total = valid_nxt;
    push_job.point_x     = in_item.point_x;
    push_job.point_y     = in_item.point_y;
    push_job.image_size  = in_item.image_size;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= 4'd0;
      valid_cnt_r <= 4'd0;
      src_bad_r   <= 1'b0;
    end else if (xfer) begin
      if (in_item.last_point) begin
        slot_r      <= 4'd0;
        valid_cnt_r <= 4'd0;
        src_bad_r   <= 1'b0;
      end else begin
        if (slot_r < pp3d_pkg::COUNT_MAX) slot_r <= slot_r + 4'd1;
        valid_cnt_r <= valid_nxt;
        src_bad_r   <= bad;
      end
    end
  end

endmodule

[src/pp3d_queue.sv]
// ----------------------------------------------------------------------------
// pp3d_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module pp3d_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  pp3d_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pp3d_pkg::job_t pop_job
);

  localparam int Depth = pp3d_pkg::QUEUE_DEPTH;
  localparam int PtrW  = pp3d_pkg::QUEUE_PTR_W;
  localparam int CntW  = pp3d_pkg::QUEUE_CNT_W;

  pp3d_pkg::job_t  mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != CntW'(Depth));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

[src/pp3d_div.sv]
// ----------------------------------------------------------------------------
// pp3d_div
// Shared restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pp3d_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pp3d_pkg::div_req_t req,
  output pp3d_pkg::div_rsp_t rsp
);

  logic [17:0] rem_r;
  logic [31:0] bits_r;
  logic [17:0] den_r;
  logic [31:0] quot_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [18:0] t1;
  logic [18:0] t2;
  logic        ge1;
  logic        ge2;
  logic [17:0] rem1;
  logic [17:0] rem2;

  always_comb begin
    t1   = {rem_r, bits_r[31]};
    ge1  = (t1 >= {1'b0, den_r});
    rem1 = ge1 ? 18'(t1 - {1'b0, den_r}) : t1[17:0];
    t2   = {rem1, bits_r[30]};
    ge2  = (t2 >= {1'b0, den_r});
    rem2 = ge2 ? 18'(t2 - {1'b0, den_r}) : t2[17:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= req.rem0;
      bits_r <= req.bits;
      den_r  <= req.den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem2;
      bits_r <= {bits_r[29:0], 2'b00};
      quot_r <= {quot_r[29:0], ge1, ge2};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.half_steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

[src/pp3d_back.sv]
// ----------------------------------------------------------------------------
// pp3d_back
// Sequencer over a shared multiplier and divider; holds the result register.
// ----------------------------------------------------------------------------
module pp3d_back #(
  parameter int MIN_DEPTH_Q16 = 3277,
  parameter int MAX_DEPTH_Q16 = 655360
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pp3d_pkg::cfg_t      cfg,
  input  logic                job_valid,
  output logic                job_pop,
  input  pp3d_pkg::job_t      job,
  output logic                out_valid,
  input  logic                out_ready,
  output pp3d_pkg::out_item_t out_item,
  output logic                div_start,
  output pp3d_pkg::div_req_t  div_req,
  input  pp3d_pkg::div_rsp_t  div_rsp
);

  typedef enum logic [18:0] {
    ST_IDLE = 19'b0000000000000000001,
    ST_XN   = 19'b0000000000000000010,
    ST_YN   = 19'b0000000000000000100,
    ST_MXX  = 19'b0000000000000001000,
    ST_MYY  = 19'b0000000000000010000,
    ST_R2   = 19'b0000000000000100000,
    ST_MR4  = 19'b0000000000001000000,
    ST_MK1  = 19'b0000000000010000000,
    ST_MK2  = 19'b0000000000100000000,
    ST_TT   = 19'b0000000001000000000,
    ST_MDU  = 19'b0000000010000000000,
    ST_MDV  = 19'b0000000100000000000,
    ST_MFB  = 19'b0000001000000000000,
    ST_DEP  = 19'b0000010000000000000,
    ST_MPX  = 19'b0000100000000000000,
    ST_DPX  = 19'b0001000000000000000,
    ST_MPY  = 19'b0010000000000000000,
    ST_DPY  = 19'b0100000000000000000,
    ST_OUT  = 19'b1000000000000000000
  } state_t;

  localparam logic [23:0] MinDepth = 24'(MIN_DEPTH_Q16);
  localparam logic [23:0] MaxDepth = 24'(MAX_DEPTH_Q16);

  state_t              state_r;
  pp3d_pkg::job_t      job_r;
  pp3d_pkg::out_item_t out_r;
  logic                out_valid_r;
  logic                issued_r;
  logic                neg_r;
  logic signed [39:0]  u_r;
  logic signed [39:0]  v_r;
  logic [30:0]         xm_r;
  logic [30:0]         ym_r;
  logic [24:0]         r2_r;
  logic [32:0]         r4_r;
  logic signed [66:0]  acc_r;
  logic signed [40:0]  t_r;
  logic signed [66:0]  prod_r;
  logic [23:0]         depth_r;
  logic signed [31:0]  px_r;
  logic signed [31:0]  py_r;

  logic signed [40:0]  mul_a;
  logic signed [25:0]  mul_b;
  logic [15:0]         abs_u;
  logic [15:0]         abs_v;
  logic [66:0]         sum;
  logic [66:0]         tadj;
  logic [66:0]         dadj;
  logic signed [39:0]  du;
  logic [24:0]         r2_val;
  logic                big;
  logic [33:0]         fb4;
  logic                dep_sat;
  logic                pneg;
  logic [66:0]         pmag;
  logic [17:0]         pden;
  logic                pos_sat;
  logic [23:0]         dq;
  logic [23:0]         dq_min;
  logic                out_free;

  function automatic logic signed [31:0] sat_quot(input logic neg, input logic [31:0] q);
    logic signed [31:0] res;
    if (neg) res = (q > 32'h8000_0000) ? 32'sh8000_0000 : 32'(-q);
    else     res = (q > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q;
    return res;
  endfunction

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    abs_u   = u_r[39] ? 16'(-u_r) : u_r[15:0];
    abs_v   = v_r[39] ? 16'(-v_r) : v_r[15:0];
    sum     = acc_r + prod_r;
    big     = (|xm_r[30:20]) || (|ym_r[30:20]);
    r2_val  = (big || sum[40:16] > 25'h100_0000) ? 25'h100_0000 : sum[40:16];
    tadj    = sum + (sum[66] ? 67'd4095 : 67'd0);
    dadj    = prod_r + (prod_r[66] ? 67'd65535 : 67'd0);
    du      = dadj[55:16];
    fb4     = {prod_r[31:0], 2'b00};
    dep_sat = ({6'b0, fb4[33:24]} >= job_r.image_size);
    pneg    = prod_r[66];
    pmag    = pneg ? 67'(-prod_r) : prod_r;
    pden    = (state_r == ST_DPY) ? {cfg.focal_y, 2'b00} : {cfg.focal_x, 2'b00};
    pos_sat = (pmag[66:32] >= {17'b0, pden});
    dq      = div_rsp.quot[23:0];
    dq_min  = (dq < MinDepth) ? MinDepth : dq;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MXX: begin mul_a = {20'b0, xm_r[20:0]}; mul_b = {5'b0, xm_r[20:0]}; end
      ST_MYY: begin mul_a = {20'b0, ym_r[20:0]}; mul_b = {5'b0, ym_r[20:0]}; end
      ST_MR4: begin mul_a = {16'b0, r2_r}; mul_b = {1'b0, r2_r}; end
      ST_MK1: begin mul_a = {16'b0, r2_r}; mul_b = {{10{cfg.radial_k1[15]}}, cfg.radial_k1}; end
      ST_MK2: begin mul_a = {8'b0, r4_r}; mul_b = {{10{cfg.radial_k2[15]}}, cfg.radial_k2}; end
      ST_MDU: begin mul_a = t_r; mul_b = {{9{u_r[16]}}, u_r[16:0]}; end
      ST_MDV: begin mul_a = t_r; mul_b = {{9{v_r[16]}}, v_r[16:0]}; end
      ST_MFB: begin mul_a = {25'b0, cfg.focal_x}; mul_b = {10'b0, cfg.baseline}; end
      ST_MPX: begin mul_a = {u_r[39], u_r}; mul_b = {1'b0, depth_r}; end
      ST_MPY: begin mul_a = {v_r[39], v_r}; mul_b = {1'b0, depth_r}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    div_req   = '0;
    div_start = 1'b0;
    case (state_r)
      ST_XN: begin
        div_req   = '{rem0: 18'd0, bits: {2'b0, abs_u, 14'b0}, den: {2'b0, cfg.focal_x},
                      half_steps: 5'd16};
        div_start = !issued_r;
      end
      ST_YN: begin
        div_req   = '{rem0: 18'd0, bits: {2'b0, abs_v, 14'b0}, den: {2'b0, cfg.focal_y},
                      half_steps: 5'd16};
        div_start = !issued_r;
      end
      ST_DEP: begin
        div_req   = '{rem0: {8'b0, fb4[33:24]}, bits: {fb4[23:0], 8'b0},
                      den: {2'b0, job_r.image_size}, half_steps: 5'd12};
        div_start = !issued_r && !dep_sat;
      end
      ST_DPX, ST_DPY: begin
        div_req   = '{rem0: pmag[49:32], bits: pmag[31:0], den: pden, half_steps: 5'd16};
        div_start = !issued_r && !pos_sat;
      end
      default: begin
        div_req   = '0;
        div_start = 1'b0;
      end
    endcase
  end

  assign job_pop = (state_r == ST_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_r   <= job;
          u_r     <= {24'b0, job.point_x} - {24'b0, cfg.center_x};
          v_r     <= {24'b0, job.point_y} - {24'b0, cfg.center_y};
          px_r    <= '0;
          py_r    <= '0;
          depth_r <= '0;
        end
      end
      ST_XN:  if (div_rsp.done) xm_r <= div_rsp.quot[30:0];
      ST_YN:  if (div_rsp.done) ym_r <= div_rsp.quot[30:0];
      ST_MYY: acc_r <= prod_r;
      ST_R2:  r2_r <= r2_val;
      ST_MK1: r4_r <= prod_r[48:16];
      ST_MK2: acc_r <= prod_r;
      ST_TT:  t_r <= tadj[52:12];
      ST_MDV: u_r <= u_r - du;
      ST_MFB: v_r <= v_r - du;
      ST_DEP: begin
        if (!issued_r && dep_sat) depth_r <= MaxDepth;
        else if (div_rsp.done)    depth_r <= (dq_min > MaxDepth) ? MaxDepth : dq_min;
      end
      ST_DPX: begin
        if (!issued_r) begin
          neg_r <= pneg;
          if (pos_sat) px_r <= pneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (div_rsp.done) begin
          px_r <= sat_quot(neg_r, div_rsp.quot);
        end
      end
      ST_DPY: begin
        if (!issued_r) begin
          neg_r <= pneg;
          if (pos_sat) py_r <= pneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (div_rsp.done) begin
          py_r <= sat_quot(neg_r, div_rsp.quot);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_r.slot         <= job_r.slot;
          out_r.point_ok     <= job_r.ok;
          out_r.pos_x        <= px_r;
          out_r.pos_y        <= py_r;
          out_r.depth        <= depth_r;
          out_r.frame_end    <= job_r.frame_end;
          out_r.frame_status <= job_r.status;
          out_r.valid_total  <= job_r.valid_total;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ready)                out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (job_valid) state_r <= job.ok ? ST_XN : ST_OUT;
        ST_XN, ST_YN: begin
          if (!issued_r) begin
            issued_r <= 1'b1;
          end else if (div_rsp.done) begin
            issued_r <= 1'b0;
            state_r  <= (state_r == ST_XN) ? ST_YN : ST_MXX;
          end
        end
        ST_MXX: state_r <= ST_MYY;
        ST_MYY: state_r <= ST_R2;
        ST_R2:  state_r <= ST_MR4;
        ST_MR4: state_r <= ST_MK1;
        ST_MK1: state_r <= ST_MK2;
        ST_MK2: state_r <= ST_TT;
        ST_TT:  state_r <= ST_MDU;
        ST_MDU: state_r <= ST_MDV;
        ST_MDV: state_r <= ST_MFB;
        ST_MFB: state_r <= ST_DEP;
        ST_DEP: begin
          if (!issued_r) begin
            if (dep_sat) state_r <= ST_MPX;
            else         issued_r <= 1'b1;
          end else if (div_rsp.done) begin
            issued_r <= 1'b0;
            state_r  <= ST_MPX;
          end
        end
        ST_MPX: state_r <= ST_DPX;
        ST_MPY: state_r <= ST_DPY;
        ST_DPX, ST_DPY: begin
          if (!issued_r) begin
            if (pos_sat) state_r <= (state_r == ST_DPX) ? ST_MPY : ST_OUT;
            else         issued_r <= 1'b1;
          end else if (div_rsp.done) begin
            issued_r <= 1'b0;
            state_r  <= (state_r == ST_DPX) ? ST_MPY : ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

[src/pp3d_checker.sv]
// ----------------------------------------------------------------------------
// pp3d_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pp3d_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input pp3d_pkg::out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped or changed while stalled");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.point_ok |->
      out_item.depth == 24'd0 && out_item.pos_x == 32'sd0 && out_item.pos_y == 32'sd0)
    else $error("dropped point carries a position");

  a_ok_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.point_ok |-> out_item.depth != 24'd0 && out_item.valid_total != 4'd0)
    else $error("computed point without depth or count");

  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.frame_status != 2'd0 |-> out_item.frame_end)
    else $error("frame status off frame end");

endmodule

bind pinhole_point_to_3d pp3d_checker u_pp3d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.payload)
);

[tb/sv/pp3d_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pp3d_scoreboard
// Watches the point and result channels and the register port, predicts each
// result of the pinhole block and compares it field by field, in order.
// ----------------------------------------------------------------------------
module pp3d_scoreboard #(
  parameter int MARKER_SLOTS     = 8,
  parameter int MIN_VALID_POINTS = 3,
  parameter int MIN_DEPTH_Q16    = 3277,
  parameter int MAX_DEPTH_Q16    = 655360
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pp3d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pp3d_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  pp3d_pkg::in_item_t              in_payload,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  pp3d_pkg::out_item_t             out_payload,
  output int                              errors,
  output int                              pending
);

  pp3d_pkg::cfg_t      regs;
  logic [3:0]          slot_cnt;
  logic [3:0]          valid_cnt;
  logic                src_bad;
  pp3d_pkg::out_item_t expected_q[$];

  assign pending = expected_q.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic project_point(input pp3d_pkg::in_item_t p);
    pp3d_pkg::out_item_t r;
    logic      bad;
    logic      ok;
    longint    u, v, xn, yn, r2, r4, t, dep, fx, fy;
    bad = src_bad | ~p.source_valid;
    ok = !bad && p.weight >= regs.min_weight && p.image_size != 0 &&
         slot_cnt < MARKER_SLOTS && regs.focal_x != 0 && regs.focal_y != 0;
    r = '0;
    if (ok) begin
      fx = longint'(regs.focal_x);
      fy = longint'(regs.focal_y);
      u = longint'(p.point_x) - longint'(regs.center_x);
      v = longint'(p.point_y) - longint'(regs.center_y);
      xn = (u * 16384) / fx;
      yn = (v * 16384) / fy;
      r2 = (xn * xn + yn * yn) / 65536;
      if (r2 > 64'sd16777216) r2 = 64'sd16777216;
      r4 = (r2 * r2) / 65536;
      t = (longint'(regs.radial_k1) * r2 + longint'(regs.radial_k2) * r4) / 4096;
      dep = (fx * longint'(regs.baseline) * 4) / longint'(p.image_size);
      if (dep < MIN_DEPTH_Q16) dep = MIN_DEPTH_Q16;
      if (dep > MAX_DEPTH_Q16) dep = MAX_DEPTH_Q16;
      r.pos_x = 32'(sat32(((u - (u * t) / 65536) * dep) / (fx * 4)));
      r.pos_y = 32'(sat32(((v - (v * t) / 65536) * dep) / (fy * 4)));
      r.depth = 24'(dep);
      if (valid_cnt < pp3d_pkg::COUNT_MAX) valid_cnt++;
    end
    r.slot = slot_cnt[2:0];
    r.point_ok = ok;
    r.frame_end = p.last_point;
    if (p.last_point) begin
      if (bad) r.frame_status = pp3d_pkg::STATUS_BAD_SOURCE;
      else if (valid_cnt < MIN_VALID_POINTS) r.frame_status = pp3d_pkg::STATUS_FEW_POINTS;
      else r.frame_status = pp3d_pkg::STATUS_OK;
    end else begin
      r.frame_status = pp3d_pkg::STATUS_OK;
    end
    r.valid_total = valid_cnt;
    expected_q.push_back(r);
    if (p.last_point) begin
      slot_cnt = '0;
      valid_cnt = '0;
      src_bad = 1'b0;
    end else begin
      if (slot_cnt < pp3d_pkg::COUNT_MAX) slot_cnt++;
      src_bad = bad;
    end
  endtask

  task automatic compare_result(input pp3d_pkg::out_item_t got);
    pp3d_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      report("result without point", 1, 0);
      return;
    end
    want = expected_q.pop_front();
    if (got.slot !== want.slot) report("slot", got.slot, want.slot);
    if (got.point_ok !== want.point_ok) report("point_ok", got.point_ok, want.point_ok);
    if (got.pos_x !== want.pos_x) report("pos_x", got.pos_x, want.pos_x);
    if (got.pos_y !== want.pos_y) report("pos_y", got.pos_y, want.pos_y);
    if (got.depth !== want.depth) report("depth", got.depth, want.depth);
    if (got.frame_end !== want.frame_end) report("frame_end", got.frame_end, want.frame_end);
    if (got.frame_status !== want.frame_status)
      report("frame_status", got.frame_status, want.frame_status);
    if (got.valid_total !== want.valid_total)
      report("valid_total", got.valid_total, want.valid_total);
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      regs <= {16'd5120, 16'd5120, 16'd10240, 16'd7680, 16'sd0, 16'sd0, 16'd3277,
               16'd16384};
      slot_cnt <= '0;
      valid_cnt <= '0;
      src_bad <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (pp3d_pkg::cfg_reg_t'(cfg_index))
          pp3d_pkg::REG_FOCAL_X:    regs.focal_x    <= cfg_data;
          pp3d_pkg::REG_FOCAL_Y:    regs.focal_y    <= cfg_data;
          pp3d_pkg::REG_CENTER_X:   regs.center_x   <= cfg_data;
          pp3d_pkg::REG_CENTER_Y:   regs.center_y   <= cfg_data;
          pp3d_pkg::REG_RADIAL_K1:  regs.radial_k1  <= cfg_data;
          pp3d_pkg::REG_RADIAL_K2:  regs.radial_k2  <= cfg_data;
          pp3d_pkg::REG_BASELINE:   regs.baseline   <= cfg_data;
          pp3d_pkg::REG_MIN_WEIGHT: regs.min_weight <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) project_point(in_payload);
      if (out_valid && out_ready) compare_result(out_payload);
    end
  end

endmodule

[tb/sv/pinhole_point_to_3d_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_point_to_3d_tb
// Drives marker points and register settings into the pinhole block under
// random idling on both channels; a scoreboard beside it checks every result.
// ----------------------------------------------------------------------------
module pinhole_point_to_3d_tb;

  localparam int CYCLE_LIMIT = 900000;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [pp3d_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pp3d_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              errors;
  int                              pending;
  int                              cycles;
  int                              send_idle_pct;
  int                              take_idle_pct;

  pp3d_in_if  in_ch ();
  pp3d_out_if out_ch ();

  pinhole_point_to_3d u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  pp3d_scoreboard u_scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_payload  (in_ch.payload),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload),
    .errors      (errors),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  task automatic write_reg(input pp3d_pkg::cfg_reg_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic send_point(input pp3d_pkg::in_item_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    while (guard < 150) begin
      @(posedge clk);
      guard++;
    end
  endtask

  function automatic pp3d_pkg::in_item_t make_point(input bit near);
    pp3d_pkg::in_item_t p;
    p.point_x = near ? 16'(10240 + $signed($urandom_range(8000)) - 4000) : 16'($urandom);
    p.point_y = near ? 16'(7680 + $signed($urandom_range(8000)) - 4000) : 16'($urandom);
    p.weight = ($urandom_range(9) == 0) ? 16'($urandom_range(16383)) : 16'($urandom);
    case ($urandom_range(9))
      0:       p.image_size = 16'd0;
      1:       p.image_size = 16'($urandom_range(1, 63));
      2, 3:    p.image_size = 16'($urandom);
      default: p.image_size = 16'($urandom_range(200, 8000));
    endcase
    p.source_valid = ($urandom_range(19) != 0);
    p.last_point = 1'b0;
    return p;
  endfunction

  task automatic send_frame(input int len, input bit near);
    pp3d_pkg::in_item_t p;
    for (int k = 0; k < len; k++) begin
      p = make_point(near);
      p.last_point = (k == len - 1);
      send_point(p);
    end
  endtask

  task automatic random_settings();
    write_reg(pp3d_pkg::REG_FOCAL_X, 16'($urandom_range(1, 65535)));
    write_reg(pp3d_pkg::REG_FOCAL_Y, 16'($urandom_range(1, 65535)));
    write_reg(pp3d_pkg::REG_CENTER_X, 16'($urandom));
    write_reg(pp3d_pkg::REG_CENTER_Y, 16'($urandom));
    write_reg(pp3d_pkg::REG_RADIAL_K1, 16'($urandom));
    write_reg(pp3d_pkg::REG_RADIAL_K2, 16'($urandom));
    write_reg(pp3d_pkg::REG_BASELINE, 16'($urandom_range(1, 65535)));
    write_reg(pp3d_pkg::REG_MIN_WEIGHT, 16'($urandom_range(20000)));
    cfg_we <= 1'b0;
  endtask

  pp3d_pkg::in_item_t pt;

  initial begin
    cycles = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    send_idle_pct = 19;
    take_idle_pct = 79;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes and special cases at reset settings
    pt = '{point_x: 16'hFFFF, point_y: 16'h0000, weight: 16'hFFFF, image_size: 16'd1,
           source_valid: 1'b1, last_point: 1'b0};
    send_point(pt);
    pt = '{point_x: 16'h0000, point_y: 16'hFFFF, weight: 16'hFFFF, image_size: 16'hFFFF,
           source_valid: 1'b1, last_point: 1'b0};
    send_point(pt);
    pt.image_size = 16'd0;
    send_point(pt);
    pt.image_size = 16'd1000;
    pt.weight = 16'd16383;
    send_point(pt);
    pt.weight = 16'd16384;
    pt.last_point = 1'b1;
    send_point(pt);
    pt.last_point = 1'b0;
    send_point(pt);
    pt.source_valid = 1'b0;
    send_point(pt);
    pt.source_valid = 1'b1;
    pt.last_point = 1'b1;
    send_point(pt);
    pt.last_point = 1'b0;
    for (int k = 0; k < 17; k++) begin
      pt.last_point = (k == 16);
      send_point(pt);
    end
    drain();

    // extreme settings, strong distortion, large radius
    write_reg(pp3d_pkg::REG_FOCAL_X, 16'd1);
    write_reg(pp3d_pkg::REG_FOCAL_Y, 16'hFFFF);
    write_reg(pp3d_pkg::REG_CENTER_X, 16'd0);
    write_reg(pp3d_pkg::REG_CENTER_Y, 16'hFFFF);
    write_reg(pp3d_pkg::REG_RADIAL_K1, 16'h7FFF);
    write_reg(pp3d_pkg::REG_RADIAL_K2, 16'h8000);
    write_reg(pp3d_pkg::REG_BASELINE, 16'hFFFF);
    write_reg(pp3d_pkg::REG_MIN_WEIGHT, 16'd0);
    cfg_we <= 1'b0;
    send_frame(5, 1'b0);
    drain();
    write_reg(pp3d_pkg::REG_FOCAL_X, 16'hFFFF);
    write_reg(pp3d_pkg::REG_FOCAL_Y, 16'd1);
    write_reg(pp3d_pkg::REG_RADIAL_K1, 16'h8000);
    write_reg(pp3d_pkg::REG_RADIAL_K2, 16'h7FFF);
    write_reg(pp3d_pkg::REG_BASELINE, 16'd1);
    write_reg(pp3d_pkg::REG_MIN_WEIGHT, 16'hFFFF);
    cfg_we <= 1'b0;
    send_frame(4, 1'b0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 79 : 0;
      take_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 19 : 0;
      for (int s = 0; s < 3; s++) begin
        if (s == 0 && phase == 0) begin
          write_reg(pp3d_pkg::REG_FOCAL_X, 16'd5120);
          write_reg(pp3d_pkg::REG_FOCAL_Y, 16'd5120);
          write_reg(pp3d_pkg::REG_CENTER_X, 16'd10240);
          write_reg(pp3d_pkg::REG_CENTER_Y, 16'd7680);
          write_reg(pp3d_pkg::REG_RADIAL_K1, 16'hF000);
          write_reg(pp3d_pkg::REG_RADIAL_K2, 16'd500);
          write_reg(pp3d_pkg::REG_BASELINE, 16'd3277);
          write_reg(pp3d_pkg::REG_MIN_WEIGHT, 16'd16384);
          cfg_we <= 1'b0;
        end else begin
          random_settings();
        end
        for (int f = 0; f < 8; f++)
          send_frame($urandom_range(1, 10), $urandom_range(3) != 0);
        drain();
      end
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
src/pp3d_pkg.sv
src/pp3d_if.sv
src/pp3d_front.sv
src/pp3d_queue.sv
src/pp3d_div.sv
src/pp3d_back.sv
src/pinhole_point_to_3d.sv
src/pp3d_checker.sv
tb/sv/pp3d_scoreboard.sv
tb/sv/pinhole_point_to_3d_tb.sv
